[rtl/core/aabbsr_pkg.sv]
// Shared types, widths and helper function of the AABB axis slide resolver.
package aabbsr_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned POS_W    = COORD_W + 1;
  localparam int unsigned EDGE_W   = COORD_W + 2;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned ACT_W    = 7;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [IDX_W-1:0]          wall_index;
    logic signed [COORD_W-1:0] corner_lo_x;
    logic signed [COORD_W-1:0] corner_lo_y;
    logic signed [COORD_W-1:0] corner_lo_z;
    logic signed [COORD_W-1:0] corner_hi_x;
    logic signed [COORD_W-1:0] corner_hi_y;
    logic signed [COORD_W-1:0] corner_hi_z;
    logic signed [COORD_W-1:0] move_x;
    logic signed [COORD_W-1:0] move_y;
    logic signed [COORD_W-1:0] move_z;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] centre_z;
  } out_word_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_W-1:0] hi;
    logic [NUM_AXES-1:0][COORD_W-1:0] lo;
  } wall_t;

  typedef struct packed {
    logic load;
    logic move;
    logic check;
  } cell_ctl_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [POS_W-1:0] value
  );
    logic signed [COORD_W-1:0] result;
    if (value[POS_W-1] != value[POS_W-2]) begin
      result = value[POS_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      result = value[COORD_W-1:0];
    end
    return result;
  endfunction

endpackage

[rtl/core/aabbsr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module aabbsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/aabbsr_cell.sv]
// One axis cell: holds the box centre, half size and velocity of one axis.
module aabbsr_cell
  import aabbsr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctl_t                 ctl_i,
  input  logic                      sel_i,
  input  logic signed [COORD_W-1:0] lo_i,
  input  logic signed [COORD_W-1:0] hi_i,
  input  logic signed [COORD_W-1:0] vel_i,
  input  logic signed [COORD_W-1:0] wall_lo_i,
  input  logic signed [COORD_W-1:0] wall_hi_i,
  input  logic                      ov_i,
  output logic                      ov_o,
  input  logic                      hit_i,
  output logic signed [POS_W-1:0]   pos_o
);

  logic signed [POS_W-1:0]   pos_q, pos_d;
  logic signed [COORD_W-1:0] half_q, half_d;
  logic signed [COORD_W-1:0] vel_q, vel_d;
  logic signed [POS_W-1:0]   sum, diff, sum_sh, diff_sh;
  logic signed [EDGE_W-1:0]  edge_lo, edge_hi, wlo_ext, whi_ext;
  logic signed [POS_W-1:0]   push_lo, push_hi;
  logic                      mine;

  always_comb begin
    sum     = POS_W'(lo_i) + POS_W'(hi_i);
    diff    = POS_W'(hi_i) - POS_W'(lo_i);
    sum_sh  = sum >>> 1;
    diff_sh = diff >>> 1;

    edge_lo = EDGE_W'(pos_q) - EDGE_W'(half_q);
    edge_hi = EDGE_W'(pos_q) + EDGE_W'(half_q);
    wlo_ext = EDGE_W'(wall_lo_i);
    whi_ext = EDGE_W'(wall_hi_i);
    mine    = (edge_lo < whi_ext) && (edge_hi > wlo_ext);

    push_lo = POS_W'(wall_lo_i) - POS_W'(half_q);
    push_hi = POS_W'(wall_hi_i) + POS_W'(half_q);

    pos_d  = pos_q;
    half_d = half_q;
    vel_d  = vel_q;
    if (ctl_i.load) begin
      pos_d  = sum_sh;
      half_d = diff_sh[COORD_W-1:0];
      vel_d  = vel_i;
    end else if (ctl_i.move && sel_i) begin
      pos_d = pos_q + POS_W'(vel_q);
    end else if (ctl_i.check && sel_i && hit_i) begin
      pos_d = (vel_q > 0) ? push_lo : push_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      half_q <= '0;
      vel_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      half_q <= half_d;
      vel_q  <= vel_d;
    end
  end

  assign ov_o  = ov_i && mine;
  assign pos_o = pos_q;

endmodule

[rtl/core/aabb_axis_slide_resolver.sv]
// Top level of the AABB axis slide resolver: wall table, sequencer and axis cells.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_word_i) carries store and
// query words. A store writes one wall into the table in the cycle it is accepted
// and gives no result. A query loads the box into the three axis cells, then moves
// along x, z and y in turn; each axis takes a move step and then one check step per
// active wall, reading the wall table one entry per cycle. A query shows its result
// on the output channel (out_valid_o, out_stall_i, out_word_o) from the finish
// state once all three axes are done, and no new word is taken until it has left
// that state. Stores are taken one per cycle while no query is running.
// The register active_q is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while idle, the block itself does not enforce this.
// Reset clears the register to zero and empties the output register; the wall
// table is not cleared. While the receiver stalls, the result is held in the
// output register and new words are still accepted; a finished query waits for
// the output register to free up before the next word is taken.
module aabb_axis_slide_resolver
  import aabbsr_pkg::*;
#(
  parameter int unsigned MAX_WALLS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ACT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o
);

  localparam int unsigned AW    = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WALLS + 1);
  localparam int unsigned WALL_W = $bits(wall_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_CHECK,
    S_FIN
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       axis_q, axis_d;
  logic [CNT_W-1:0] walk_q, walk_d;
  logic [ACT_W-1:0] active_q, active_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_word_q, out_word_d;

  logic             in_accept, is_query, last_axis, take;
  logic [31:0]      idx_ext, act_ext;
  logic [CNT_W-1:0] count, walk_next;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  wall_t            wall_wr, wall_rd;
  logic [NUM_AXES-1:0] sel;
  cell_ctl_t        ctl;
  logic [NUM_AXES:0] ov;
  logic signed [COORD_W-1:0] cell_lo [NUM_AXES];
  logic signed [COORD_W-1:0] cell_hi [NUM_AXES];
  logic signed [COORD_W-1:0] cell_vel [NUM_AXES];
  logic signed [POS_W-1:0]   cell_pos [NUM_AXES];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_query   = (in_word_i.operation == OP_QUERY);

  assign act_ext   = 32'(active_q);
  assign count     = (act_ext > MAX_WALLS) ? CNT_W'(MAX_WALLS) : CNT_W'(active_q);
  assign walk_next = walk_q + CNT_W'(1);
  assign last_axis = (axis_q == 2'd2);
  assign take      = !out_valid_q || !out_stall_i;

  assign idx_ext   = 32'(in_word_i.wall_index);
  assign ram_we    = in_accept && (in_word_i.operation == OP_STORE) && (idx_ext < MAX_WALLS);
  assign ram_waddr = idx_ext[AW-1:0];
  assign ram_raddr = (state_q == S_MOVE) ? '0 : walk_next[AW-1:0];

  assign wall_wr.lo[0] = in_word_i.corner_lo_x;
  assign wall_wr.lo[1] = in_word_i.corner_lo_y;
  assign wall_wr.lo[2] = in_word_i.corner_lo_z;
  assign wall_wr.hi[0] = in_word_i.corner_hi_x;
  assign wall_wr.hi[1] = in_word_i.corner_hi_y;
  assign wall_wr.hi[2] = in_word_i.corner_hi_z;

  aabbsr_ram #(
    .WIDTH(WALL_W),
    .DEPTH(MAX_WALLS)
  ) u_wall_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wall_wr),
    .raddr_i(ram_raddr),
    .rdata_o(wall_rd)
  );

  // Axes are resolved in the order x, z, y.
  always_comb begin
    case (axis_q)
      2'd0:    sel = 3'b001;
      2'd1:    sel = 3'b100;
      2'd2:    sel = 3'b010;
      default: sel = 3'b000;
    endcase
  end

  assign ctl.load  = in_accept && is_query;
  assign ctl.move  = (state_q == S_MOVE);
  assign ctl.check = (state_q == S_CHECK);

  assign cell_lo[0]  = in_word_i.corner_lo_x;
  assign cell_lo[1]  = in_word_i.corner_lo_y;
  assign cell_lo[2]  = in_word_i.corner_lo_z;
  assign cell_hi[0]  = in_word_i.corner_hi_x;
  assign cell_hi[1]  = in_word_i.corner_hi_y;
  assign cell_hi[2]  = in_word_i.corner_hi_z;
  assign cell_vel[0] = in_word_i.move_x;
  assign cell_vel[1] = in_word_i.move_y;
  assign cell_vel[2] = in_word_i.move_z;

  assign ov[0] = 1'b1;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_cell
    aabbsr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .sel_i    (sel[a]),
      .lo_i     (cell_lo[a]),
      .hi_i     (cell_hi[a]),
      .vel_i    (cell_vel[a]),
      .wall_lo_i(wall_rd.lo[a]),
      .wall_hi_i(wall_rd.hi[a]),
      .ov_i     (ov[a]),
      .ov_o     (ov[a+1]),
      .hit_i    (ov[NUM_AXES]),
      .pos_o    (cell_pos[a])
    );
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    walk_d      = walk_q;
    active_d    = cfg_we_i ? cfg_wdata_i : active_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && is_query) begin
          state_d = S_MOVE;
          axis_d  = 2'd0;
          walk_d  = '0;
        end
      end
      S_MOVE: begin
        walk_d = '0;
        if (count != '0) begin
          state_d = S_CHECK;
        end else if (last_axis) begin
          state_d = S_FIN;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      S_CHECK: begin
        if (walk_next == count) begin
          if (last_axis) begin
            state_d = S_FIN;
          end else begin
            state_d = S_MOVE;
            axis_d  = axis_q + 2'd1;
          end
        end else begin
          walk_d = walk_next;
        end
      end
      S_FIN: begin
        if (take) begin
          state_d             = S_IDLE;
          out_valid_d         = 1'b1;
          out_word_d.centre_x = sat_coord(cell_pos[0]);
          out_word_d.centre_y = sat_coord(cell_pos[1]);
          out_word_d.centre_z = sat_coord(cell_pos[2]);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 2'd0;
      walk_q      <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      walk_q      <= walk_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (walk_q < count))
    else $error("wall walk index ran past the active wall count");

  a_store_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE))
    else $error("wall table written while a query is running");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (axis_q <= 2'd2))
    else $error("axis step out of range");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result word loaded outside the finish state");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_query) |=> (state_q == S_MOVE) && (axis_q == 2'd0))
    else $error("accepted query did not start on the x axis");

endmodule
